// File: rtl/core/ead_pkg.sv
// ----------------------------------------------------------------------------
// ead_pkg - shared types and constants of the EMA anomaly detector
// Step codes, mode and event codes, register indexes and saturation helper.
// ----------------------------------------------------------------------------
package ead_pkg;

   // Mode codes
   localparam logic [1:0] MODE_INIT   = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_ALERT  = 2'd2;

   // Event codes
   localparam logic [1:0] EVT_NONE    = 2'd0;
   localparam logic [1:0] EVT_RAISED  = 2'd1;
   localparam logic [1:0] EVT_CLEARED = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_ALPHA_TEMP      = 3'd0;
   localparam logic [2:0] REG_ERR_GAIN        = 3'd1;
   localparam logic [2:0] REG_K_SENSITIVITY   = 3'd2;
   localparam logic [2:0] REG_MIN_THRESHOLD   = 3'd3;
   localparam logic [2:0] REG_HYSTERESIS_FRAC = 3'd4;

   localparam logic [15:0] TEMP_AVERAGE_RESET = 16'd5120;
   localparam logic [8:0]  GAIN_ONE           = 9'd256;

   // Datapath step codes issued by the controller
   typedef enum logic [3:0] {
      STEP_NONE   = 4'd0,
      STEP_LOAD   = 4'd1,
      STEP_KE     = 4'd2,
      STEP_AT     = 4'd3,
      STEP_AA     = 4'd4,
      STEP_HY     = 4'd5,
      STEP_BE     = 4'd6,
      STEP_BA     = 4'd7,
      STEP_COMMIT = 4'd8
   } step_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic [8:0]  alpha_temp;
      logic [8:0]  err_gain;
      logic [11:0] k_sensitivity;
      logic [15:0] min_threshold;
      logic [8:0]  hysteresis_frac;
   } cfg_type;

   // Saturate a value to 16 bits
   function automatic logic [15:0] sat16(input logic [19:0] v);
      sat16 = (v[19:16] != 4'd0) ? 16'hFFFF : v[15:0];
   endfunction

   // Gains above one act as one
   function automatic logic [8:0] clamp_gain(input logic [8:0] g);
      clamp_gain = g[8] ? GAIN_ONE : g;
   endfunction

endpackage

// File: rtl/core/ead_csr.sv
// ----------------------------------------------------------------------------
// ead_csr - configuration registers
// Holds the five gain and threshold registers written over the csr channel.
// ----------------------------------------------------------------------------
module ead_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output ead_pkg::cfg_type cfg
);

   ead_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ead_pkg::REG_ALPHA_TEMP:      cfg_in.alpha_temp      = csr_data[8:0];
            ead_pkg::REG_ERR_GAIN:        cfg_in.err_gain        = csr_data[8:0];
            ead_pkg::REG_K_SENSITIVITY:   cfg_in.k_sensitivity   = csr_data[11:0];
            ead_pkg::REG_MIN_THRESHOLD:   cfg_in.min_threshold   = csr_data;
            ead_pkg::REG_HYSTERESIS_FRAC: cfg_in.hysteresis_frac = csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_temp      <= 9'd26;
         cfg_ff.err_gain        <= 9'd26;
         cfg_ff.k_sensitivity   <= 12'd768;
         cfg_ff.min_threshold   <= 16'd512;
         cfg_ff.hysteresis_frac <= 9'd205;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/ead_dp.sv
// ----------------------------------------------------------------------------
// ead_dp - datapath of the EMA anomaly detector
// One shared 16x12 multiplier stepped by the controller, the detector state
// and the result payload register.
// ----------------------------------------------------------------------------
module ead_dp (
   input  logic             clock,
   input  logic             reset,
   input  ead_pkg::cmd_type cmd,
   input  ead_pkg::cfg_type cfg,
   input  logic [7:0]       temperature,
   output logic [1:0]       mode_now,
   output logic [1:0]       alert_event,
   output logic [7:0]       latched_temp,
   output logic [7:0]       temp_reported,
   output logic [15:0]      average_out
);

   // Detector state
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] ta_ff, ta_in;
   logic [15:0] ea_ff, ea_in;
   logic [15:0] lat_ff, lat_in;

   // Working registers of one item
   logic [7:0]  t_ff;
   logic [15:0] err_ff;
   logic [27:0] prod_ff;
   logic [15:0] thr_ff;
   logic [15:0] acc_ff;
   logic [15:0] nta_ff;
   logic [15:0] clr_ff;

   // Result payload
   logic [1:0]  out_mode_ff;
   logic [1:0]  out_evt_ff;
   logic [7:0]  out_lat_ff;
   logic [7:0]  out_t_ff;
   logic [15:0] out_avg_ff;

   logic [8:0]  ga, gb, gh;
   logic [15:0] tq, tq_t;
   logic [15:0] mul_a;
   logic [11:0] mul_b;
   logic [15:0] prod_hi;
   logic [15:0] blend_sum;
   logic [15:0] nea;
   logic [1:0]  evt_in;

   assign ga   = ead_pkg::clamp_gain(cfg.alpha_temp);
   assign gb   = ead_pkg::clamp_gain(cfg.err_gain);
   assign gh   = ead_pkg::clamp_gain(cfg.hysteresis_frac);
   assign tq   = {temperature, 8'd0};
   assign tq_t = {t_ff, 8'd0};

   // Product >> 8, saturated (only the scaled error average can exceed 16 bits)
   assign prod_hi   = ead_pkg::sat16(prod_ff[27:8]);
   assign blend_sum = ead_pkg::sat16({3'd0, {1'b0, acc_ff} + {1'b0, prod_hi}});
   assign nea       = blend_sum;

   // Select multiplier operands for this step
   always_comb begin
      mul_a = 16'd0;
      mul_b = 12'd0;
      case (cmd.step)
         ead_pkg::STEP_KE: begin
            mul_a = ea_ff;
            mul_b = cfg.k_sensitivity;
         end
         ead_pkg::STEP_AT: begin
            mul_a = tq_t;
            mul_b = {3'd0, ga};
         end
         ead_pkg::STEP_AA: begin
            mul_a = ta_ff;
            mul_b = {3'd0, ead_pkg::GAIN_ONE - ga};
         end
         ead_pkg::STEP_HY: begin
            mul_a = thr_ff;
            mul_b = {3'd0, gh};
         end
         ead_pkg::STEP_BE: begin
            mul_a = err_ff;
            mul_b = {3'd0, gb};
         end
         ead_pkg::STEP_BA: begin
            mul_a = ea_ff;
            mul_b = {3'd0, ead_pkg::GAIN_ONE - gb};
         end
         default: ;
      endcase
   end

   // Decide the mode transition at commit
   always_comb begin
      mode_in = mode_ff;
      ta_in   = ta_ff;
      ea_in   = ea_ff;
      lat_in  = lat_ff;
      evt_in  = ead_pkg::EVT_NONE;
      case (mode_ff)
         ead_pkg::MODE_NORMAL: begin
            if (err_ff > thr_ff) begin
               mode_in = ead_pkg::MODE_ALERT;
               lat_in  = ta_ff;
               evt_in  = ead_pkg::EVT_RAISED;
            end else begin
               ea_in = nea;
            end
            ta_in = nta_ff;
         end
         ead_pkg::MODE_ALERT: begin
            if (err_ff < clr_ff) begin
               mode_in = ead_pkg::MODE_NORMAL;
               evt_in  = ead_pkg::EVT_CLEARED;
               ea_in   = nea;
            end
            ta_in = nta_ff;
         end
         default: begin
            // Seeding step
            ta_in   = tq_t;
            ea_in   = 16'd0;
            mode_in = ead_pkg::MODE_NORMAL;
         end
      endcase
   end

   // Detector state: update on commit only
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ead_pkg::MODE_INIT;
         ta_ff   <= ead_pkg::TEMP_AVERAGE_RESET;
         ea_ff   <= 16'd0;
         lat_ff  <= 16'd0;
      end else if (cmd.step == ead_pkg::STEP_COMMIT) begin
         mode_ff <= mode_in;
         ta_ff   <= ta_in;
         ea_ff   <= ea_in;
         lat_ff  <= lat_in;
      end
   end

   // Working registers and payload
   always_ff @(posedge clock) begin
      case (cmd.step)
         ead_pkg::STEP_LOAD: begin
            t_ff   <= temperature;
            err_ff <= (tq >= ta_ff) ? tq - ta_ff : ta_ff - tq;
         end
         ead_pkg::STEP_AT: begin
            thr_ff <= ead_pkg::sat16({3'd0, {1'b0, prod_hi} + {1'b0, cfg.min_threshold}});
         end
         ead_pkg::STEP_AA: acc_ff <= prod_hi;
         ead_pkg::STEP_HY: nta_ff <= blend_sum;
         ead_pkg::STEP_BE: clr_ff <= prod_hi;
         ead_pkg::STEP_BA: acc_ff <= prod_hi;
         ead_pkg::STEP_COMMIT: begin
            out_mode_ff <= mode_in;
            out_evt_ff  <= evt_in;
            out_lat_ff  <= lat_in[15:8];
            out_t_ff    <= t_ff;
            out_avg_ff  <= ta_in;
         end
         default: ;
      endcase
      if (cmd.step == ead_pkg::STEP_KE || cmd.step == ead_pkg::STEP_AT ||
          cmd.step == ead_pkg::STEP_AA || cmd.step == ead_pkg::STEP_HY ||
          cmd.step == ead_pkg::STEP_BE || cmd.step == ead_pkg::STEP_BA) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign mode_now      = out_mode_ff;
   assign alert_event   = out_evt_ff;
   assign latched_temp  = out_lat_ff;
   assign temp_reported = out_t_ff;
   assign average_out   = out_avg_ff;

endmodule

// File: rtl/core/ead_ctrl.sv
// ----------------------------------------------------------------------------
// ead_ctrl - step sequencer of the EMA anomaly detector
// Accepts an item, walks the datapath through its multiply steps and commits
// once the result register is free.
// ----------------------------------------------------------------------------
module ead_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ead_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_KE     = 8'b0000_0010,
      ST_AT     = 8'b0000_0100,
      ST_AA     = 8'b0000_1000,
      ST_HY     = 8'b0001_0000,
      ST_BE     = 8'b0010_0000,
      ST_BA     = 8'b0100_0000,
      ST_COMMIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Sequence the steps
   always_comb begin
      state_in     = state_ff;
      cmd.step     = ead_pkg::STEP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.step = ead_pkg::STEP_LOAD;
               state_in = ST_KE;
            end
         end
         ST_KE: begin
            cmd.step = ead_pkg::STEP_KE;
            state_in = ST_AT;
         end
         ST_AT: begin
            cmd.step = ead_pkg::STEP_AT;
            state_in = ST_AA;
         end
         ST_AA: begin
            cmd.step = ead_pkg::STEP_AA;
            state_in = ST_HY;
         end
         ST_HY: begin
            cmd.step = ead_pkg::STEP_HY;
            state_in = ST_BE;
         end
         ST_BE: begin
            cmd.step = ead_pkg::STEP_BE;
            state_in = ST_BA;
         end
         ST_BA: begin
            cmd.step = ead_pkg::STEP_BA;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Hold until the result register is free
            if (out_free) begin
               cmd.step     = ead_pkg::STEP_COMMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/ema_anomaly_detector_hysteresis.sv
// ----------------------------------------------------------------------------
// ema_anomaly_detector_hysteresis - adaptive threshold temperature detector
// Usage:
//   req channel: one 8-bit temperature sample per item (req_tdata).
//   rsp channel: one result per item; rsp_tuser carries mode and event,
//   rsp_tdata the latched average byte, the echoed sample and the updated
//   temperature average in Q8.8.
//   csr channel: register writes, always ready; write only while idle.
//   The result is offered once its commit step has run: the sample and its
//   error are loaded at the accepting edge, six steps of the single shared
//   16x12 multiplier follow, then a commit step that holds while a result waits.
//   The multiplier chain sets the rate: a new item is taken only once the
//   last one is committed, since req_tready is high only between items.
//   Reset clears the mode to init, the temperature average to 20.0, the
//   error average and latched average to zero, and loads the register
//   defaults. When the receiver stalls, the result waits in its output
//   register; the next item is still accepted and worked, and its commit
//   holds until the waiting result is taken.
// ----------------------------------------------------------------------------
module ema_anomaly_detector_hysteresis (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] temperature
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] latched_temp, [15:8] temp_reported,
                                    // [31:16] average_out
   output logic [3:0]  rsp_tuser,   // [1:0] mode_now, [3:2] alert_event
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   ead_pkg::cmd_type cmd;
   ead_pkg::cfg_type cfg;
   logic [1:0]       mode_now;
   logic [1:0]       alert_event;
   logic [7:0]       latched_temp;
   logic [7:0]       temp_reported;
   logic [15:0]      average_out;

   ead_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ead_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ead_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .temperature   (req_tdata),
      .mode_now      (mode_now),
      .alert_event   (alert_event),
      .latched_temp  (latched_temp),
      .temp_reported (temp_reported),
      .average_out   (average_out)
   );

   // Pack the result
   assign rsp_tdata = {average_out, temp_reported, latched_temp};
   assign rsp_tuser = {alert_event, mode_now};

endmodule

// File: rtl/core/ead_checker.sv
// ----------------------------------------------------------------------------
// ead_checker - port checks of the EMA anomaly detector
// Watches the top level's channels and flags illegal results over time.
// ----------------------------------------------------------------------------
module ead_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [3:0]  rsp_tuser
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // One item at a time: no acceptance right after an acceptance
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while one is in work");

   // A result never reports the init mode or the unused code
   a_mode_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] == ead_pkg::MODE_NORMAL ||
                      rsp_tuser[1:0] == ead_pkg::MODE_ALERT))
      else $error("result with bad mode");

   // Event and mode agree
   a_evt_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[3:2] == ead_pkg::EVT_NONE ||
                      (rsp_tuser[3:2] == ead_pkg::EVT_RAISED &&
                       rsp_tuser[1:0] == ead_pkg::MODE_ALERT) ||
                      (rsp_tuser[3:2] == ead_pkg::EVT_CLEARED &&
                       rsp_tuser[1:0] == ead_pkg::MODE_NORMAL)))
      else $error("event does not match mode");

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind ema_anomaly_detector_hysteresis ead_checker u_ead_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser)
);
